/* hdl/srf_pkg.sv */
`timescale 1ns / 1ps

package srf_pkg;

  // Sizes
  localparam int PATTERN_MAX   = 8;
  localparam int POSITION_BITS = 16;
  localparam int START_BITS    = 16;
  localparam int LEN_BITS      = 4;
  localparam int IDX_BITS      = $clog2(PATTERN_MAX);
  localparam int SEQ_LEN       = 1 << LEN_BITS;
  localparam int QUEUE_DEPTH   = 2;
  localparam int QPTR_BITS     = $clog2(QUEUE_DEPTH);
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 8 * PATTERN_MAX;

  typedef logic [7:0]               byte_t;
  typedef logic [LEN_BITS-1:0]      len_t;
  typedef logic [POSITION_BITS-1:0] pos_t;

  // Register indexes of the configuration port
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_PATTERN    = 2'd0,
    REG_LENGTH     = 2'd1,
    REG_START      = 2'd2,
    REG_REMOVE_ALL = 2'd3
  } cfg_reg_t;

  // Configuration seen by the front end
  typedef struct packed {
    logic [8*PATTERN_MAX-1:0] pattern;
    len_t                     length;
    logic [START_BITS-1:0]    start_index;
    logic                     remove_all;
  } cfg_t;

  // One queue entry: the words that one input word releases
  typedef struct packed {
    byte_t [PATTERN_MAX-1:0] bytes;
    len_t                    count;
    logic                    last;
  } batch_t;

  // Clamp the programmed length to 1..PATTERN_MAX
  function automatic len_t eff_length(input len_t raw);
    len_t res;
    if (raw == '0) begin
      res = len_t'(1);
    end else if (raw > len_t'(PATTERN_MAX)) begin
      res = len_t'(PATTERN_MAX);
    end else begin
      res = raw;
    end
    return res;
  endfunction

endpackage

/* hdl/srf_front.sv */
`timescale 1ns / 1ps

module srf_front (
  input  logic              clk,
  input  logic              rst_n,
  input  srf_pkg::cfg_t     cfg,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_byte,
  input  logic              in_last,
  input  logic              q_full,
  output logic              q_push,
  output srf_pkg::batch_t   q_data
);

  srf_pkg::byte_t win_r   [srf_pkg::PATTERN_MAX];
  srf_pkg::byte_t win_nxt [srf_pkg::PATTERN_MAX];
  srf_pkg::len_t  fill_r, fill_nxt;
  srf_pkg::pos_t  pos_r, pos_nxt;
  logic           removed_r, removed_nxt;

  srf_pkg::byte_t seq   [srf_pkg::SEQ_LEN];
  srf_pkg::byte_t shwin [srf_pkg::PATTERN_MAX];
  srf_pkg::len_t  len, pre_pops, fill_p1, consumed, emit_cnt;
  logic [srf_pkg::LEN_BITS:0] adv;
  srf_pkg::pos_t  pos_chk;
  logic           full, match, allowed, drop, pop, accept;

  // Saturating advance of the string position
  function automatic srf_pkg::pos_t sat_add(input srf_pkg::pos_t base,
                                            input logic [srf_pkg::LEN_BITS:0] amt);
    logic [srf_pkg::POSITION_BITS:0] sum;
    sum = (srf_pkg::POSITION_BITS+1)'(base) + (srf_pkg::POSITION_BITS+1)'(amt);
    return sum[srf_pkg::POSITION_BITS] ? '1 : sum[srf_pkg::POSITION_BITS-1:0];
  endfunction

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // Classify the incoming word against the window
  always_comb begin
    len      = srf_pkg::eff_length(cfg.length);
    pre_pops = (fill_r >= len) ? fill_r - len + srf_pkg::len_t'(1) : '0;
    fill_p1  = fill_r + srf_pkg::len_t'(1);
    full     = (pre_pops != '0) || (fill_p1 == len);

    // window contents followed by the new byte
    for (int i = 0; i < srf_pkg::SEQ_LEN; i++) begin
      if (i < srf_pkg::PATTERN_MAX && srf_pkg::len_t'(i) < fill_r) begin
        seq[i] = win_r[i];
      end else begin
        seq[i] = in_byte;
      end
    end

    // window after the forced pops, compared to the pattern
    match = 1'b1;
    for (int k = 0; k < srf_pkg::PATTERN_MAX; k++) begin
      shwin[k] = seq[srf_pkg::LEN_BITS'(pre_pops + srf_pkg::len_t'(k))];
      if (srf_pkg::len_t'(k) < len && shwin[k] != cfg.pattern[8*k +: 8]) begin
        match = 1'b0;
      end
    end

    pos_chk = sat_add(pos_r, (srf_pkg::LEN_BITS+1)'(pre_pops));
    allowed = ((srf_pkg::POSITION_BITS+srf_pkg::START_BITS)'(pos_chk) >=
               (srf_pkg::POSITION_BITS+srf_pkg::START_BITS)'(cfg.start_index)) &&
              (cfg.remove_all || !removed_r);
    drop     = full && allowed && match;
    pop      = full && !drop;
    consumed = pre_pops + srf_pkg::len_t'(pop);

    if (in_last) begin
      emit_cnt = drop ? pre_pops : fill_p1;
    end else begin
      emit_cnt = consumed;
    end

    if (drop) begin
      adv = (srf_pkg::LEN_BITS+1)'(pre_pops) + (srf_pkg::LEN_BITS+1)'(len);
    end else begin
      adv = (srf_pkg::LEN_BITS+1)'(consumed);
    end

    // next window state
    for (int i = 0; i < srf_pkg::PATTERN_MAX; i++) begin
      win_nxt[i] = seq[srf_pkg::LEN_BITS'(consumed + srf_pkg::len_t'(i))];
    end
    fill_nxt    = (in_last || drop) ? '0 : fill_p1 - consumed;
    pos_nxt     = in_last ? '0 : sat_add(pos_r, adv);
    removed_nxt = in_last ? 1'b0 : (removed_r || drop);

    // released words go to the queue as one entry
    for (int i = 0; i < srf_pkg::PATTERN_MAX; i++) begin
      q_data.bytes[i] = seq[i];
    end
    q_data.count = emit_cnt;
    q_data.last  = in_last;
    q_push       = accept && (emit_cnt != '0 || in_last);
  end

  // Hold window bytes
  always_ff @(posedge clk) begin
    if (accept) begin
      win_r <= win_nxt;
    end
  end

  // Advance window bookkeeping
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r    <= '0;
      pos_r     <= '0;
      removed_r <= 1'b0;
    end else if (accept) begin
      fill_r    <= fill_nxt;
      pos_r     <= pos_nxt;
      removed_r <= removed_nxt;
    end
  end

endmodule

/* hdl/srf_queue.sv */
`timescale 1ns / 1ps

module srf_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  srf_pkg::batch_t push_data,
  input  logic            pop,
  output logic            full,
  output logic            empty,
  output srf_pkg::batch_t head
);

  srf_pkg::batch_t               entries_r [srf_pkg::QUEUE_DEPTH];
  logic [srf_pkg::QPTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [srf_pkg::QPTR_BITS:0]   count_r, count_nxt;
  logic                          do_push, do_pop;

  assign full    = (count_r == (srf_pkg::QPTR_BITS+1)'(srf_pkg::QUEUE_DEPTH));
  assign empty   = (count_r == '0);
  assign head    = entries_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  // Advance pointers and count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == srf_pkg::QPTR_BITS'(srf_pkg::QUEUE_DEPTH-1)) ?
                   '0 : wr_ptr_r + srf_pkg::QPTR_BITS'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == srf_pkg::QPTR_BITS'(srf_pkg::QUEUE_DEPTH-1)) ?
                   '0 : rd_ptr_r + srf_pkg::QPTR_BITS'(1);
    end
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + (srf_pkg::QPTR_BITS+1)'(1);
      2'b01:   count_nxt = count_r - (srf_pkg::QPTR_BITS+1)'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

/* hdl/srf_back.sv */
`timescale 1ns / 1ps

module srf_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_empty,
  input  srf_pkg::batch_t head,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [7:0]      out_byte,
  output logic            out_has_byte,
  output logic            out_last
);

  logic [srf_pkg::IDX_BITS-1:0] idx_r, idx_nxt;
  logic                         out_valid_r, out_valid_nxt;
  srf_pkg::byte_t               out_byte_r, out_byte_nxt;
  logic                         has_byte_r, has_byte_nxt;
  logic                         out_last_r, out_last_nxt;
  logic                         load, final_word;

  // Pick the next word of the head entry
  always_comb begin
    load          = !q_empty && (!out_valid_r || out_ready);
    final_word    = (head.count == '0) ||
                    (srf_pkg::len_t'(idx_r) + srf_pkg::len_t'(1) == head.count);
    q_pop         = load && final_word;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    has_byte_nxt  = has_byte_r;
    out_last_nxt  = out_last_r;
    if (load) begin
      out_valid_nxt = 1'b1;
      idx_nxt       = final_word ? '0 : idx_r + srf_pkg::IDX_BITS'(1);
      if (head.count == '0) begin
        out_byte_nxt = '0;
        has_byte_nxt = 1'b0;
        out_last_nxt = 1'b1;
      end else begin
        out_byte_nxt = head.bytes[idx_r];
        has_byte_nxt = 1'b1;
        out_last_nxt = head.last && final_word;
      end
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold output word
  always_ff @(posedge clk) begin
    out_byte_r <= out_byte_nxt;
    has_byte_r <= has_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_byte     = out_byte_r;
  assign out_has_byte = has_byte_r;
  assign out_last     = out_last_r;

endmodule

/* hdl/substring_removal_filter_unit.sv */
`timescale 1ns / 1ps

// Streaming substring delete filter.
// Input channel (in_valid/in_ready): one string byte per word, in_last on
// the final byte. Output channel (out_valid/out_ready): filtered bytes;
// out_has_byte low marks a bare end word, out_last closes each string.
// Config port: cfg_wr_en writes cfg_data into register cfg_index (pattern,
// length, start index, remove-all); write it only while the block is idle.
// Throughput: one input word per cycle while strings stream and the
// queue is not full; each input word releases at most one output word,
// except at a string end or after the length shrinks mid-string, where up
// to 8 words come out, one per cycle while out_ready is high, from the
// output side. The queue is written at the edge that accepts the input
// word, and the output register loads it from the queue head once the
// register is empty or being taken; the word then shows on out_valid.
// The front end updates the window in the cycle a word is accepted and
// queues the released words; a 2-entry queue feeds the output register.
// When out_ready is low the output word holds, the queue fills and then
// in_ready drops. Reset empties the queue and the window, drops out_valid
// and restores the register defaults (length 1, everything else 0).
module substring_removal_filter_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [srf_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [srf_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [7:0]                          in_byte,
  input  logic                                in_last,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [7:0]                          out_byte,
  output logic                                out_has_byte,
  output logic                                out_last
);

  srf_pkg::cfg_t   cfg_r;
  srf_pkg::batch_t push_data, head;
  logic            q_push, q_pop, q_full, q_empty;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pattern     <= '0;
      cfg_r.length      <= srf_pkg::len_t'(1);
      cfg_r.start_index <= '0;
      cfg_r.remove_all  <= 1'b0;
    end else if (cfg_wr_en) begin
      case (srf_pkg::cfg_reg_t'(cfg_index))
        srf_pkg::REG_PATTERN:    cfg_r.pattern     <= cfg_data;
        srf_pkg::REG_LENGTH:     cfg_r.length      <= cfg_data[srf_pkg::LEN_BITS-1:0];
        srf_pkg::REG_START:      cfg_r.start_index <= cfg_data[srf_pkg::START_BITS-1:0];
        srf_pkg::REG_REMOVE_ALL: cfg_r.remove_all  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  srf_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_byte  (in_byte),
    .in_last  (in_last),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (push_data)
  );

  srf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (push_data),
    .pop       (q_pop),
    .full      (q_full),
    .empty     (q_empty),
    .head      (head)
  );

  srf_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_empty      (q_empty),
    .head         (head),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .out_has_byte (out_has_byte),
    .out_last     (out_last)
  );

endmodule

/* hdl/srf_checker.sv */
`timescale 1ns / 1ps

module srf_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_has_byte,
  input logic       out_last
);

  // Stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) &&
    $stable(out_has_byte) && $stable(out_last))
    else $error("output word changed while stalled");

  // A word without a byte is always a zero end marker
  a_bare_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_has_byte |-> out_last && out_byte == 8'd0)
    else $error("bare word is not a clean end marker");

  // Reset empties the output side
  a_rst_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // Reset leaves the queue empty, so input is taken at once
  a_rst_in: assert property (@(posedge clk)
    !rst_n |=> in_ready)
    else $error("input not ready after reset");

endmodule

bind substring_removal_filter_unit srf_checker u_srf_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_byte     (out_byte),
  .out_has_byte (out_has_byte),
  .out_last     (out_last)
);

/* sim/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned SETTLE       = 4;
  localparam int unsigned DRAIN        = 8;
  localparam int unsigned HOLD_CYCLES  = 80;
  localparam int unsigned PHASE_WORDS  = 30;
  localparam int unsigned POS_LIMIT    = (1 << srf_pkg::POSITION_BITS) - 1;
  localparam int          PLAN_ROWS    = 38;

  typedef struct packed {
    srf_pkg::byte_t data;
    logic           has;
    logic           last;
  } out_word_t;

  typedef enum logic [1:0] {
    ROW_REG,
    ROW_WORD,
    ROW_CHECKED
  } row_kind_t;

  typedef struct packed {
    row_kind_t         kind;
    srf_pkg::cfg_reg_t idx;
    logic [63:0]       val;
    srf_pkg::byte_t    b;
    logic              last;
    out_word_t         want;
  } row_t;

  logic                              clk;
  logic                              rst_n;
  logic                              cfg_wr_en;
  logic [srf_pkg::CFG_IDX_BITS-1:0]  cfg_index;
  logic [srf_pkg::CFG_DATA_BITS-1:0] cfg_data;
  logic                              in_valid;
  logic                              in_ready;
  logic [7:0]                        in_byte;
  logic                              in_last;
  logic                              out_valid;
  logic                              out_ready;
  logic [7:0]                        out_byte;
  logic                              out_has_byte;
  logic                              out_last;

  // Typed expectation that rides along with the current input word
  logic      word_typed;
  out_word_t word_want;

  // Predictor copy of the registers and the window
  logic [63:0]    pat_r;
  srf_pkg::len_t  len_r;
  logic [15:0]    start_r;
  logic           rall_r;
  srf_pkg::byte_t win [srf_pkg::PATTERN_MAX];
  int unsigned    fill;
  int unsigned    opos;
  bit             removed;

  out_word_t     step_words [$];
  out_word_t     pending_words [$];
  out_word_t     head_word;

  int unsigned   fail_count;
  int unsigned   cycle_count;
  int unsigned   word_count;

  // Stimulus side view of the current setting
  logic [63:0]    cur_pat;
  int unsigned    cur_len;
  srf_pkg::byte_t alph [3];

  bit            quiet;
  bit            hold_req;
  int unsigned   stall_left;
  int unsigned   run_left;

  // Directed words: reset defaults, clamped lengths, full-width pattern,
  // greedy matching, first-match-only, start position, shrink mid-string
  row_t plan [PLAN_ROWS] = '{
    '{ROW_CHECKED, srf_pkg::REG_PATTERN,    64'h0, 8'h41, 1'b1, '{8'h41, 1'b1, 1'b1}},
    '{ROW_CHECKED, srf_pkg::REG_PATTERN,    64'h0, 8'h00, 1'b1, '{8'h00, 1'b0, 1'b1}},
    '{ROW_REG,     srf_pkg::REG_LENGTH,     64'h0, 8'h00, 1'b0, '0},
    '{ROW_REG,     srf_pkg::REG_PATTERN,    64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0, '0},
    '{ROW_CHECKED, srf_pkg::REG_PATTERN,    64'h0, 8'hFF, 1'b1, '{8'h00, 1'b0, 1'b1}},
    '{ROW_CHECKED, srf_pkg::REG_PATTERN,    64'h0, 8'h00, 1'b1, '{8'h00, 1'b1, 1'b1}},
    '{ROW_REG,     srf_pkg::REG_LENGTH,     64'hF, 8'h00, 1'b0, '0},
    '{ROW_REG,     srf_pkg::REG_PATTERN,    64'h6867_6665_6463_6261, 8'h00, 1'b0, '0},
    '{ROW_REG,     srf_pkg::REG_REMOVE_ALL, 64'h1, 8'h00, 1'b0, '0},
    '{ROW_WORD,    srf_pkg::REG_PATTERN,    64'h0, 8'h61, 1'b0, '0},
    '{ROW_WORD,    srf_pkg::REG_PATTERN,    64'h0, 8'h62, 1'b0, '0},
    '{ROW_WORD,    srf_pkg::REG_PATTERN,    64'h0, 8'h63, 1'b0, '0},
    '{ROW_WORD,    srf_pkg::REG_PATTERN,    64'h0, 8'h64, 1'b0, '0},
    '{ROW_WORD,    srf_pkg::REG_PATTERN,    64'h0, 8'h65, 1'b0, '0},
    '{ROW_WORD,    srf_pkg::REG_PATTERN,    64'h0, 8'h66, 1'b0, '0},
    '{ROW_WORD,    srf_pkg::REG_PATTERN,    64'h0, 8'h67, 1'b0, '0},
    '{ROW_WORD,    srf_pkg::REG_PATTERN,    64'h0, 8'h68, 1'b0, '0},
    '{ROW_CHECKED, srf_pkg::REG_PATTERN,    64'h0, 8'h7F, 1'b1, '{8'h7F, 1'b1, 1'b1}},
    '{ROW_REG,     srf_pkg::REG_LENGTH,     64'h3, 8'h00, 1'b0, '0},
    '{ROW_REG,     srf_pkg::REG_PATTERN,    64'h63_6261, 8'h00, 1'b0, '0},
    '{ROW_REG,     srf_pkg::REG_START,      64'h1, 8'h00, 1'b0, '0},
    '{ROW_REG,     srf_pkg::REG_REMOVE_ALL, 64'h0, 8'h00, 1'b0, '0},
    '{ROW_WORD,    srf_pkg::REG_PATTERN,    64'h0, 8'h78, 1'b0, '0},
    '{ROW_WORD,    srf_pkg::REG_PATTERN,    64'h0, 8'h61, 1'b0, '0},
    '{ROW_WORD,    srf_pkg::REG_PATTERN,    64'h0, 8'h62, 1'b0, '0},
    '{ROW_WORD,    srf_pkg::REG_PATTERN,    64'h0, 8'h63, 1'b0, '0},
    '{ROW_WORD,    srf_pkg::REG_PATTERN,    64'h0, 8'h61, 1'b0, '0},
    '{ROW_WORD,    srf_pkg::REG_PATTERN,    64'h0, 8'h62, 1'b0, '0},
    '{ROW_WORD,    srf_pkg::REG_PATTERN,    64'h0, 8'h63, 1'b1, '0},
    '{ROW_REG,     srf_pkg::REG_LENGTH,     64'h5, 8'h00, 1'b0, '0},
    '{ROW_REG,     srf_pkg::REG_START,      64'hFFFF, 8'h00, 1'b0, '0},
    '{ROW_REG,     srf_pkg::REG_REMOVE_ALL, 64'h1, 8'h00, 1'b0, '0},
    '{ROW_WORD,    srf_pkg::REG_PATTERN,    64'h0, 8'h80, 1'b0, '0},
    '{ROW_WORD,    srf_pkg::REG_PATTERN,    64'h0, 8'h01, 1'b0, '0},
    '{ROW_WORD,    srf_pkg::REG_PATTERN,    64'h0, 8'h02, 1'b0, '0},
    '{ROW_WORD,    srf_pkg::REG_PATTERN,    64'h0, 8'h03, 1'b0, '0},
    '{ROW_REG,     srf_pkg::REG_LENGTH,     64'h2, 8'h00, 1'b0, '0},
    '{ROW_WORD,    srf_pkg::REG_PATTERN,    64'h0, 8'h55, 1'b1, '0}
  };

  substring_removal_filter_unit u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_byte      (in_byte),
    .in_last      (in_last),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .out_has_byte (out_has_byte),
    .out_last     (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic log_mismatch(input string what);
    $display("ERROR @%0t: %s", $time, what);
    fail_count++;
  endtask

  // Clamp a programmed length to 1..PATTERN_MAX
  function automatic int unsigned span_of(input srf_pkg::len_t raw);
    if (raw == '0) return 1;
    if (raw > srf_pkg::len_t'(srf_pkg::PATTERN_MAX)) return srf_pkg::PATTERN_MAX;
    return int'(raw);
  endfunction

  // Saturating string position
  task automatic bump_pos(input int unsigned by);
    if (opos + by >= POS_LIMIT) begin
      opos = POS_LIMIT;
    end else begin
      opos = opos + by;
    end
  endtask

  // Release the oldest window byte and slide by one
  task automatic emit_oldest();
    out_word_t w;
    w.data = win[0];
    w.has  = 1'b1;
    w.last = 1'b0;
    step_words.push_back(w);
    for (int i = 1; i < fill; i++) win[i-1] = win[i];
    fill--;
    bump_pos(1);
  endtask

  function automatic bit window_hit(input int unsigned n);
    bit hit;
    hit = 1'b1;
    for (int k = 0; k < n; k++) begin
      if (win[k] != pat_r[8*k +: 8]) hit = 1'b0;
    end
    return hit;
  endfunction

  // Predict the words that one accepted input word releases
  task automatic filter_word(input srf_pkg::byte_t b, input logic lst);
    int unsigned l;
    out_word_t   w;
    l = span_of(len_r);
    // drain down to L-1 bytes when the length shrank
    while (fill >= l && fill > 0) emit_oldest();
    if (fill < srf_pkg::PATTERN_MAX) begin
      win[fill] = b;
      fill++;
    end
    if (fill == l) begin
      if (opos >= start_r && (rall_r || !removed) && window_hit(l)) begin
        fill = 0;
        bump_pos(l);
        removed = 1'b1;
      end else begin
        emit_oldest();
      end
    end
    // flush at string end; a bare end word closes an empty tail
    if (lst) begin
      while (fill > 0) emit_oldest();
      if (step_words.size() > 0) begin
        w = step_words.pop_back();
        w.last = 1'b1;
        step_words.push_back(w);
      end else begin
        w = '0;
        w.last = 1'b1;
        step_words.push_back(w);
      end
      opos    = 0;
      removed = 1'b0;
    end
  endtask

  // Track register writes, predict accepted input words, check output words
  always @(posedge clk) begin
    if (!rst_n) begin
      pat_r   = '0;
      len_r   = srf_pkg::len_t'(1);
      start_r = '0;
      rall_r  = 1'b0;
      fill    = 0;
      opos    = 0;
      removed = 1'b0;
      pending_words.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          srf_pkg::REG_PATTERN:    pat_r   = cfg_data;
          srf_pkg::REG_LENGTH:     len_r   = cfg_data[srf_pkg::LEN_BITS-1:0];
          srf_pkg::REG_START:      start_r = cfg_data[15:0];
          srf_pkg::REG_REMOVE_ALL: rall_r  = cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        step_words.delete();
        filter_word(in_byte, in_last);
        if (word_typed) begin
          pending_words.push_back(word_want);
        end else begin
          foreach (step_words[k]) pending_words.push_back(step_words[k]);
        end
      end
      if (out_valid && out_ready) begin
        if (pending_words.size() == 0) begin
          log_mismatch($sformatf("unexpected word byte=%h has=%b last=%b",
                                 out_byte, out_has_byte, out_last));
        end else begin
          head_word = pending_words.pop_front();
          if (out_byte !== head_word.data)
            log_mismatch($sformatf("out_byte %h, want %h", out_byte, head_word.data));
          if (out_has_byte !== head_word.has)
            log_mismatch($sformatf("out_has_byte %b, want %b", out_has_byte,
                                   head_word.has));
          if (out_last !== head_word.last)
            log_mismatch($sformatf("out_last %b, want %b", out_last, head_word.last));
        end
      end
    end
  end

  // Hard stop
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Output side: random stalls and runs, one long hold-off on request
  initial begin
    out_ready  = 1'b0;
    stall_left = 0;
    run_left   = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if (quiet) begin
        out_ready <= 1'b1;
      end else if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = HOLD_CYCLES - 1;
        out_ready  <= 1'b0;
      end else if (run_left > 0) begin
        out_ready <= 1'b1;
        run_left--;
      end else if ($urandom_range(0, 2) == 0) begin
        stall_left = $urandom_range(1, 9) - 1;
        out_ready  <= 1'b0;
      end else begin
        run_left  = $urandom_range(1, 16) - 1;
        out_ready <= 1'b1;
      end
    end
  end

  // Offer one word and hold it until accepted; entered and left at a falling edge
  task automatic send_word(input srf_pkg::byte_t b, input logic lst, input logic typed,
                           input out_word_t want);
    int unsigned gap;
    gap = 0;
    if (!quiet && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 9);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_byte    <= b;
    in_last    <= lst;
    word_typed <= typed;
    word_want  <= want;
    do @(posedge clk); while (!(in_valid && in_ready));
    word_count++;
    @(negedge clk);
  endtask

  // Write a register once the block has gone quiet
  task automatic write_reg(input srf_pkg::cfg_reg_t idx, input logic [63:0] val);
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // One string: mostly pattern copies and near-misses, sometimes pure noise
  task automatic send_string(input bit noisy);
    srf_pkg::byte_t s [$];
    int unsigned    pieces, cut, mid;
    if (noisy) begin
      repeat ($urandom_range(1, 12)) s.push_back(srf_pkg::byte_t'($urandom));
    end else begin
      pieces = $urandom_range(1, 5);
      repeat (pieces) begin
        case ($urandom_range(0, 5))
          0, 1: for (int k = 0; k < cur_len; k++) s.push_back(cur_pat[8*k +: 8]);
          2: begin
            cut = $urandom_range(1, cur_len);
            for (int k = 0; k < cut; k++) s.push_back(cur_pat[8*k +: 8]);
          end
          3: s.push_back(alph[$urandom_range(0, 2)]);
          4: s.push_back(srf_pkg::byte_t'($urandom));
          default: begin
            s.push_back(alph[$urandom_range(0, 2)]);
            s.push_back(alph[$urandom_range(0, 2)]);
          end
        endcase
      end
    end
    // now and then change the length partway through, but never during a hold-off
    mid = s.size();
    if (s.size() > 2 && stall_left == 0 && $urandom_range(0, 9) == 0)
      mid = $urandom_range(1, s.size() - 1);
    foreach (s[k]) begin
      if (k == mid) write_reg(srf_pkg::REG_LENGTH, 64'($urandom_range(0, 15)));
      send_word(s[k], k == s.size() - 1, 1'b0, '0);
    end
  endtask

  // Random setting, then strings until the word budget is spent
  task automatic random_phase(input int unsigned words, input bit press);
    int unsigned raw_len, target;
    logic [63:0] pat;
    logic [15:0] start;
    case ($urandom_range(0, 9))
      0:       raw_len = 0;
      9:       raw_len = $urandom_range(9, 15);
      default: raw_len = $urandom_range(1, 8);
    endcase
    for (int k = 0; k < 3; k++) alph[k] = srf_pkg::byte_t'($urandom);
    for (int k = 0; k < 8; k++) pat[8*k +: 8] = alph[$urandom_range(0, 2)];
    start = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4));
    cur_pat = pat;
    cur_len = span_of(srf_pkg::len_t'(raw_len));
    write_reg(srf_pkg::REG_PATTERN, pat);
    write_reg(srf_pkg::REG_LENGTH, 64'(raw_len));
    write_reg(srf_pkg::REG_START, 64'(start));
    write_reg(srf_pkg::REG_REMOVE_ALL, 64'($urandom_range(0, 1)));
    // hold off the receiver while this phase keeps offering words
    if (press) hold_req = 1'b1;
    target = word_count + words;
    while (word_count < target) send_string($urandom_range(0, 5) == 0);
  endtask

  initial begin : stimulus
    rst_n       = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    in_valid    = 1'b0;
    in_byte     = '0;
    in_last     = 1'b0;
    word_typed  = 1'b0;
    word_want   = '0;
    fail_count  = 0;
    cycle_count = 0;
    word_count  = 0;
    quiet       = 1'b0;
    hold_req    = 1'b0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // walk the directed table
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_REG) begin
        write_reg(plan[i].idx, plan[i].val);
      end else begin
        send_word(plan[i].b, plan[i].last, plan[i].kind == ROW_CHECKED, plan[i].want);
      end
    end

    // random settings; one phase runs under a long output hold-off
    for (int p = 0; p < 10; p++) begin
      random_phase(PHASE_WORDS, p == 4);
    end

    // closing stretch at full rate on both sides
    quiet = 1'b1;
    repeat (2) random_phase(PHASE_WORDS, 1'b0);

    // drain and finish
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);
    if (fail_count == 0 && pending_words.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
